### hw/rtl/rdu_pkg.sv
package rdu_pkg;

  localparam int MAX_TOKEN_CHARS = 10;
  localparam int POS_W = $clog2(MAX_TOKEN_CHARS + 2);
  localparam int IDX_W = $clog2(MAX_TOKEN_CHARS);
  localparam int KEY_N = 9;
  localparam int KEY_W = 8 * KEY_N;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [2:0] ROLE_DAY   = 3'd0;
  localparam logic [2:0] ROLE_MONTH = 3'd1;
  localparam logic [2:0] ROLE_YEAR  = 3'd2;
  localparam logic [2:0] ROLE_TIME  = 3'd3;
  localparam logic [2:0] ROLE_ZONE  = 3'd4;
  localparam logic [2:0] ROLE_DONE  = 3'd5;
  localparam logic [2:0] TOK_SAT    = 3'd7;

  localparam logic [KEY_W-1:0] MONTH_W [12] = '{
    "jan", "feb", "mar", "apr", "may", "jun",
    "jul", "aug", "sep", "oct", "nov", "dec"
  };
  localparam logic [KEY_W-1:0] DAY_SHORT [7] = '{
    "mon", "tue", "wed", "thu", "fri", "sat", "sun"
  };
  localparam logic [KEY_W-1:0] DAY_LONG [7] = '{
    "monday", "tuesday", "wednesday", "thursday", "friday", "saturday", "sunday"
  };
  localparam logic [3:0] DAY_LEN [7] = '{4'd6, 4'd7, 4'd9, 4'd8, 4'd6, 4'd8, 4'd6};
  localparam logic [KEY_W-1:0] ZONE_GMT = "gmt";
  localparam logic [KEY_W-1:0] ZONE_UTC = "utc";
  localparam logic [KEY_W-1:0] ZONE_UT  = "ut";

  localparam logic [22:0] EPOCH_DAYS = 23'd719468;
  localparam logic signed [41:0] LAST_SECOND = 42'sd253402300799;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIN, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5
  } rdu_state_e;

  typedef struct packed {
    logic accept;
    logic fin;
    logic c1;
    logic c2;
    logic c3;
    logic c4;
    logic load;
  } rdu_cmd_t;

  typedef struct packed {
    logic slot_free;
  } rdu_sts_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // days from March 1 to the first of month m
  function automatic logic [8:0] month_off(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:  r = 9'd0;
      4'd4:  r = 9'd31;
      4'd5:  r = 9'd61;
      4'd6:  r = 9'd92;
      4'd7:  r = 9'd122;
      4'd8:  r = 9'd153;
      4'd9:  r = 9'd184;
      4'd10: r = 9'd214;
      4'd11: r = 9'd245;
      4'd12: r = 9'd275;
      4'd1:  r = 9'd306;
      4'd2:  r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2: r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // 8 is 1 mod 7: fold octal digits
  function automatic logic [2:0] mod7(input logic [22:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) +
         6'(x[17:15]) + 6'(x[20:18]) + 6'(x[22:21]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 4'(s2[3]) + 4'(s2[2:0]);
    if (s3 >= 4'd7) s3 = s3 - 4'd7;
    return s3[2:0];
  endfunction

endpackage

### hw/rtl/rdu_if.sv
interface rdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;
  modport source(output valid, output char_byte, output last_byte, input ready);
  modport sink(input valid, input char_byte, input last_byte, output ready);
endinterface

interface rdu_out_if;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic signed [58:0] unix_us;
  modport source(output valid, output valid_res, output unix_us, input ready);
  modport sink(input valid, input valid_res, input unix_us, output ready);
endinterface

### hw/rtl/rdu_ctrl.sv
module rdu_ctrl
  import rdu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  rdu_sts_t sts_i,
  output rdu_cmd_t cmd_o
);

  rdu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_C1;
      ST_C1:  state_d = ST_C2;
      ST_C2:  state_d = ST_C3;
      ST_C3:  state_d = ST_C4;
      ST_C4:  state_d = ST_C5;
      ST_C5: begin
        if (sts_i.slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_FIN: cmd_o.fin = 1'b1;
      ST_C1:  cmd_o.c1 = 1'b1;
      ST_C2:  cmd_o.c2 = 1'b1;
      ST_C3:  cmd_o.c3 = 1'b1;
      ST_C4:  cmd_o.c4 = 1'b1;
      ST_C5:  cmd_o.load = sts_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C5 && !sts_i.slot_free) |=> state_q == ST_C5)
    else $error("result step left without a free slot");
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && in_last_i) |=> state_q == ST_FIN)
    else $error("last item did not start the finish step");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_o.accept)
    else $error("item taken while converting");

endmodule

### hw/rtl/rdu_dp.sv
module rdu_dp
  import rdu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdu_cmd_t           cmd_i,
  output rdu_sts_t           sts_o,
  input  logic [7:0]         char_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               valid_res_o,
  output logic signed [58:0] unix_us_o
);

  // token scanner state
  logic [2:0]       tok_q, tok_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             in_tok_q, in_tok_d;
  logic             stray_q, stray_d;
  logic             failed_q, failed_d;
  logic             wd_seen_q, wd_seen_d;
  logic [7:0]       chars_q [MAX_TOKEN_CHARS];
  logic [7:0]       last_char_q;
  logic             buf_we;
  logic [IDX_W-1:0] buf_idx;
  logic [POS_W-1:0] pos_eff;

  // parsed fields
  logic [2:0]  wd_num_q;
  logic [6:0]  day_q;
  logic [3:0]  mon_q;
  logic [13:0] year_q;
  logic [4:0]  hr_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_q;
  logic [10:0] zmin_q;
  logic        zneg_q;

  // conversion pipeline
  logic [13:0]        ye_q;
  logic [6:0]         qe_q;
  logic [9:0]         doy_q;
  logic               date_ok_q;
  logic [22:0]        dnum_q;
  logic signed [23:0] days_q;
  logic signed [18:0] tod_q;
  logic               wd_ok_q;
  logic signed [41:0] secs_q;
  logic               out_valid_q;
  logic               res_ok_q;
  logic signed [58:0] us_q;

  // token evaluation
  logic [7:0]       f [MAX_TOKEN_CHARS];
  logic             dg [8];
  logic [3:0]       dv [8];
  logic [KEY_W-1:0] key_a, key_b;
  logic [POS_W-1:0] len_m1;
  logic [2:0]       role;
  logic             tok_ok, is_wd;
  logic             set_day, set_mon, set_year, set_time, set_zone, set_wd;
  logic [6:0]       day_v;
  logic [3:0]       mon_v;
  logic [13:0]      yr2, yr3, yr4, year_v;
  logic [6:0]       th, tm, ts, zh, zm;
  logic [2:0]       wd_v;
  logic             wd_hit, mon_hit, time_ok, zone_ok, year_ok;

  logic is_ws, is_ows, finish;

  always_comb begin
    for (int i = 0; i < MAX_TOKEN_CHARS; i++) f[i] = fold(chars_q[i]);
    for (int i = 0; i < 8; i++) begin
      dg[i] = is_digit(chars_q[i]);
      dv[i] = chars_q[i][3:0];
    end
    len_m1 = pos_q - POS_W'(1);
    key_a  = '0;
    key_b  = '0;
    for (int i = 0; i < KEY_N; i++) begin
      if (POS_W'(i) < pos_q)  key_a = {key_a[KEY_W-9:0], f[i]};
      if (POS_W'(i) < len_m1) key_b = {key_b[KEY_W-9:0], f[i]};
    end
  end

  always_comb begin
    role     = tok_q - 3'(wd_seen_q);
    is_wd    = (tok_q == 3'd0) && (last_char_q == CH_COMMA);
    tok_ok   = 1'b0;
    set_day  = 1'b0;
    set_mon  = 1'b0;
    set_year = 1'b0;
    set_time = 1'b0;
    set_zone = 1'b0;
    set_wd   = 1'b0;

    wd_hit = 1'b0;
    wd_v   = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if ((len_m1 == POS_W'(3) && key_b == DAY_SHORT[i]) ||
          (len_m1 == POS_W'(DAY_LEN[i]) && key_b == DAY_LONG[i])) begin
        wd_hit = 1'b1;
        wd_v   = 3'(i + 1);
      end
    end
    mon_hit = 1'b0;
    mon_v   = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (pos_q == POS_W'(3) && key_a == MONTH_W[i]) begin
        mon_hit = 1'b1;
        mon_v   = 4'(i + 1);
      end
    end

    day_v = (pos_q == POS_W'(1)) ? 7'(dv[0]) : 7'(dv[0]) * 7'd10 + 7'(dv[1]);
    yr2   = 14'(dv[0]) * 14'd10 + 14'(dv[1]);
    yr3   = yr2 * 14'd10 + 14'(dv[2]);
    yr4   = yr3 * 14'd10 + 14'(dv[3]);
    year_v  = yr4;
    year_ok = 1'b0;
    if (pos_q == POS_W'(2) && dg[0] && dg[1]) begin
      year_ok = 1'b1;
      year_v  = yr2 + ((yr2 >= 14'd50) ? 14'd1900 : 14'd2000);
    end else if (pos_q == POS_W'(3) && dg[0] && dg[1] && dg[2]) begin
      year_ok = 1'b1;
      year_v  = yr3 + 14'd1900;
    end else if (pos_q == POS_W'(4) && dg[0] && dg[1] && dg[2] && dg[3]) begin
      year_ok = yr4 >= 14'd1900;
      year_v  = yr4;
    end

    th = 7'(dv[0]) * 7'd10 + 7'(dv[1]);
    tm = 7'(dv[3]) * 7'd10 + 7'(dv[4]);
    ts = (pos_q == POS_W'(8)) ? 7'(dv[6]) * 7'd10 + 7'(dv[7]) : 7'd0;
    time_ok = (pos_q == POS_W'(5) || pos_q == POS_W'(8)) && chars_q[2] == CH_COLON &&
              dg[0] && dg[1] && dg[3] && dg[4] &&
              (pos_q == POS_W'(5) || (chars_q[5] == CH_COLON && dg[6] && dg[7])) &&
              th <= 7'd23 && tm <= 7'd59 && ts <= 7'd59;

    zh = 7'(dv[1]) * 7'd10 + 7'(dv[2]);
    zm = 7'(dv[3]) * 7'd10 + 7'(dv[4]);
    zone_ok = pos_q == POS_W'(5) && (chars_q[0] == CH_PLUS || chars_q[0] == CH_MINUS) &&
              dg[1] && dg[2] && dg[3] && dg[4] && zh <= 7'd23 && zm <= 7'd59;

    if (pos_q > POS_W'(MAX_TOKEN_CHARS)) begin
      tok_ok = 1'b0;
      is_wd  = 1'b0;
    end else if (is_wd) begin
      tok_ok = (pos_q > POS_W'(1)) && wd_hit;
      set_wd = 1'b1;
    end else begin
      case (role)
        ROLE_DAY: begin
          tok_ok  = (pos_q == POS_W'(1) && dg[0]) || (pos_q == POS_W'(2) && dg[0] && dg[1]);
          set_day = 1'b1;
        end
        ROLE_MONTH: begin
          tok_ok  = mon_hit;
          set_mon = 1'b1;
        end
        ROLE_YEAR: begin
          tok_ok   = year_ok;
          set_year = 1'b1;
        end
        ROLE_TIME: begin
          tok_ok   = time_ok;
          set_time = 1'b1;
        end
        ROLE_ZONE: begin
          tok_ok   = zone_ok || (pos_q == POS_W'(3) && (key_a == ZONE_GMT || key_a == ZONE_UTC))
                     || (pos_q == POS_W'(2) && key_a == ZONE_UT);
          set_zone = 1'b1;
        end
        default: tok_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    is_ws   = char_i == CH_SPACE || char_i == CH_TAB;
    is_ows  = char_i >= CH_LF && char_i <= CH_CR;
    finish  = in_tok_q && ((cmd_i.accept && (is_ws || is_ows)) || cmd_i.fin);
    pos_eff = in_tok_q ? pos_q : '0;
    buf_we  = 1'b0;
    buf_idx = pos_eff[IDX_W-1:0];

    tok_d     = tok_q;
    pos_d     = pos_q;
    in_tok_d  = in_tok_q;
    stray_d   = stray_q;
    failed_d  = failed_q;
    wd_seen_d = wd_seen_q;

    if (finish) begin
      in_tok_d = 1'b0;
      if (tok_q != TOK_SAT) tok_d = tok_q + 3'd1;
      if (!tok_ok) failed_d = 1'b1;
      if (is_wd) wd_seen_d = 1'b1;
    end
    if (cmd_i.accept && is_ows && (in_tok_q || tok_q != 3'd0)) stray_d = 1'b1;
    if (cmd_i.accept && !is_ws && !is_ows) begin
      if (stray_q) failed_d = 1'b1;
      in_tok_d = 1'b1;
      buf_we   = pos_eff < POS_W'(MAX_TOKEN_CHARS);
      pos_d    = (pos_eff <= POS_W'(MAX_TOKEN_CHARS)) ? pos_eff + POS_W'(1) : pos_eff;
    end
    // start the next string from scratch
    if (cmd_i.load) begin
      tok_d     = '0;
      pos_d     = '0;
      in_tok_d  = 1'b0;
      stray_d   = 1'b0;
      failed_d  = 1'b0;
      wd_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      pos_q     <= '0;
      in_tok_q  <= 1'b0;
      stray_q   <= 1'b0;
      failed_q  <= 1'b0;
      wd_seen_q <= 1'b0;
    end else begin
      tok_q     <= tok_d;
      pos_q     <= pos_d;
      in_tok_q  <= in_tok_d;
      stray_q   <= stray_d;
      failed_q  <= failed_d;
      wd_seen_q <= wd_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      chars_q[buf_idx] <= char_i;
      last_char_q      <= char_i;
    end
    if (finish) begin
      if (set_wd)   wd_num_q <= wd_v;
      if (set_day)  day_q    <= day_v;
      if (set_mon)  mon_q    <= mon_v;
      if (set_year) year_q   <= year_v;
      if (set_time) begin
        hr_q  <= th[4:0];
        min_q <= tm[5:0];
        sec_q <= ts[5:0];
      end
      if (set_zone) begin
        zmin_q <= zone_ok ? 11'(zh) * 11'd60 + 11'(zm) : 11'd0;
        zneg_q <= zone_ok && chars_q[0] == CH_MINUS;
      end
    end
  end

  // calendar conversion
  logic [13:0] ye_c;
  logic [26:0] pe, py;
  logic [6:0]  qy;
  logic [13:0] ry;
  logic        leap;
  logic [23:0] dsum;
  logic [2:0]  wd_calc;
  logic [18:0] tod_base, tod_zone;
  logic signed [34:0] dmul;
  logic signed [55:0] umul;

  always_comb begin
    ye_c     = year_q - ((mon_q <= 4'd2) ? 14'd1 : 14'd0);
    pe       = 27'(ye_c) * 27'd5243;
    py       = 27'(year_q) * 27'd5243;
    qy       = py[25:19];
    ry       = year_q - 14'(qy) * 14'd100;
    leap     = (year_q[1:0] == 2'd0 && ry != 14'd0) || (ry == 14'd0 && qy[1:0] == 2'd0);
    dsum     = 24'(ye_q) * 24'd365 + 24'(ye_q[13:2]) - 24'(qe_q) + 24'(qe_q[6:2])
               + 24'(doy_q);
    wd_calc  = mod7(dnum_q + 23'd2) + 3'd1;
    tod_base = 19'(hr_q) * 19'd3600 + 19'(min_q) * 19'd60 + 19'(sec_q);
    tod_zone = 19'(zmin_q) * 19'd60;
    dmul     = 35'(days_q) * 35'sd675;
    umul     = 56'(secs_q) * 56'sd15625;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.c1) begin
      ye_q      <= ye_c;
      qe_q      <= pe[25:19];
      doy_q     <= 10'(month_off(mon_q)) + 10'(day_q) - 10'd1;
      date_ok_q <= mon_q >= 4'd1 && mon_q <= 4'd12 && day_q >= 7'd1 &&
                   day_q <= 7'(month_len(mon_q, leap));
    end
    if (cmd_i.c2) dnum_q <= dsum[22:0];
    if (cmd_i.c3) begin
      days_q  <= $signed(24'(dnum_q) - 24'(EPOCH_DAYS));
      tod_q   <= $signed(zneg_q ? tod_base + tod_zone : tod_base - tod_zone);
      wd_ok_q <= !wd_seen_q || wd_calc == wd_num_q;
    end
    if (cmd_i.c4) secs_q <= (42'(dmul) <<< 7) + 42'(tod_q);
  end

  logic res_ok;
  assign res_ok = !failed_q && (tok_q - 3'(wd_seen_q)) == ROLE_DONE && date_ok_q &&
                  wd_ok_q && secs_q <= LAST_SECOND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_ok_q <= res_ok;
      us_q     <= res_ok ? $signed({umul[52:0], 6'b0}) : '0;
    end
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = res_ok_q;
  assign unix_us_o       = us_q;

  a_zero_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ok_q) |-> us_q == '0)
    else $error("invalid result carries a time");
  a_tok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_tok_q |-> pos_q != '0)
    else $error("open token with no bytes");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
  a_clean_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (tok_q == '0 && !in_tok_q && !failed_q))
    else $error("scanner not cleared after a string");

endmodule

### hw/rtl/rfc5322_date_to_unix_us_top.sv
// Channel  Dir  Payload                        Handshake
// in_i     in   char_byte[7:0], last_byte      valid/ready
// out_o    out  valid_res, unix_us[58:0] sgn   valid/ready
//
// Bytes are taken one per cycle while a string is being scanned.
// After the last byte come the finish step, the four-step calendar conversion
// and the load step; the result is registered at the end of them and input
// ready is low throughout. A result still waiting on out_o.ready stretches
// the load step until it is taken.
// A registered result waits for out_o.ready while the next string streams in.
// Reset (rst_ni low, asynchronous) clears the scanner and drops any result.
module rfc5322_date_to_unix_us_top
  import rdu_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  rdu_in_if.sink    in_i,
  rdu_out_if.source out_o
);

  rdu_cmd_t cmd;
  rdu_sts_t sts;

  rdu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_byte),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rdu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .char_i      (in_i.char_byte),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .valid_res_o (out_o.valid_res),
    .unix_us_o   (out_o.unix_us)
  );

endmodule
